### hdl/deq_pkg.sv
`default_nettype none

package deq_pkg;

   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int WORD_W = 32;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_FRONT      = 3'd4,
      CMD_BACK       = 3'd5,
      CMD_SIZE       = 3'd6,
      CMD_CLEAR      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ERROR = 2'd1,
      ST_VALUE = 2'd2
   } rsp_status_type;

   typedef enum logic [1:0] {
      ADDR_FRONT,
      ADDR_FRONT_DEC,
      ADDR_TAIL,
      ADDR_LAST
   } addr_sel_type;

   typedef enum logic [1:0] {
      FRONT_HOLD,
      FRONT_INC,
      FRONT_DEC
   } front_op_type;

   typedef enum logic [1:0] {
      COUNT_HOLD,
      COUNT_INC,
      COUNT_DEC,
      COUNT_CLR
   } count_op_type;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_SIZE,
      RSP_MEM
   } rsp_sel_type;

   typedef struct packed {
      logic           load;
      logic           write;
      logic           read;
      addr_sel_type   addr_sel;
      front_op_type   front_op;
      count_op_type   count_op;
      logic           rsp_en;
      rsp_status_type rsp_status;
      rsp_sel_type    rsp_sel;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    full;
   } dp_status_type;

endpackage

`default_nettype wire

### hdl/deq_ctrl.sv
`default_nettype none

module deq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire deq_pkg::dp_status_type dp_status,
   output deq_pkg::ctl_type            ctl,
   output logic                        busy
);
   import deq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      ctl            = '0;
      ctl.addr_sel   = ADDR_FRONT;
      ctl.front_op   = FRONT_HOLD;
      ctl.count_op   = COUNT_HOLD;
      ctl.rsp_status = ST_OK;
      ctl.rsp_sel    = RSP_ZERO;
      state_in       = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (dp_status.cmd)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  ctl.rsp_en = 1'b1;
                  if (dp_status.full) begin
                     ctl.rsp_status = ST_ERROR;
                  end else begin
                     ctl.write    = 1'b1;
                     ctl.count_op = COUNT_INC;
                     if (dp_status.cmd == CMD_PUSH_FRONT) begin
                        ctl.addr_sel = ADDR_FRONT_DEC;
                        ctl.front_op = FRONT_DEC;
                     end else begin
                        ctl.addr_sel = ADDR_TAIL;
                     end
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK: begin
                  if (dp_status.empty) begin
                     ctl.rsp_en     = 1'b1;
                     ctl.rsp_status = ST_ERROR;
                  end else begin
                     ctl.read = 1'b1;
                     state_in = S_READ;
                     if (dp_status.cmd == CMD_POP_FRONT || dp_status.cmd == CMD_FRONT) begin
                        ctl.addr_sel = ADDR_FRONT;
                     end else begin
                        ctl.addr_sel = ADDR_LAST;
                     end
                     if (dp_status.cmd == CMD_POP_FRONT) begin
                        ctl.front_op = FRONT_INC;
                     end
                     if (dp_status.cmd == CMD_POP_FRONT || dp_status.cmd == CMD_POP_BACK) begin
                        ctl.count_op = COUNT_DEC;
                     end
                  end
               end
               CMD_SIZE: begin
                  ctl.rsp_en     = 1'b1;
                  ctl.rsp_status = ST_VALUE;
                  ctl.rsp_sel    = RSP_SIZE;
               end
               CMD_CLEAR: begin
                  ctl.rsp_en   = 1'b1;
                  ctl.count_op = COUNT_CLR;
               end
               default: begin
                  ctl.rsp_en     = 1'b1;
                  ctl.rsp_status = ST_ERROR;
               end
            endcase
         end
         S_READ: begin
            ctl.rsp_en     = 1'b1;
            ctl.rsp_status = ST_VALUE;
            ctl.rsp_sel    = RSP_MEM;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

### hdl/deq_datapath.sv
`default_nettype none

module deq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire deq_pkg::ctl_type              ctl,
   input  wire deq_pkg::cmd_type              req_command,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_data_in,
   output deq_pkg::dp_status_type             dp_status,
   output logic                               rsp_strobe,
   output deq_pkg::rsp_status_type            rsp_status,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_value
);
   import deq_pkg::*;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] mem_q_ff;

   cmd_type                  cmd_ff;
   logic signed [WORD_W-1:0] data_ff;
   logic [IDX_W-1:0]         front_ff;
   logic [IDX_W-1:0]         front_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [IDX_W-1:0]         front_dec;
   logic [IDX_W-1:0]         front_inc;
   logic [SUM_W-1:0]         sum_raw;
   logic [SUM_W-1:0]         sum_wrap;
   logic [IDX_W-1:0]         addr;

   logic                     rsp_strobe_ff;
   rsp_status_type           rsp_status_ff;
   logic signed [WORD_W-1:0] rsp_value_ff;

   assign front_dec = (front_ff == '0) ? IDX_LAST : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_LAST) ? '0 : front_ff + 1'b1;

   always_comb begin
      sum_raw = {{(SUM_W-IDX_W){1'b0}}, front_ff} + {1'b0, count_ff};
      if (ctl.addr_sel == ADDR_LAST) begin
         sum_raw = sum_raw - 1'b1;
      end
      sum_wrap = (sum_raw >= SUM_WRAP) ? sum_raw - SUM_WRAP : sum_raw;
   end

   always_comb begin
      unique case (ctl.addr_sel)
         ADDR_FRONT:     addr = front_ff;
         ADDR_FRONT_DEC: addr = front_dec;
         ADDR_TAIL,
         ADDR_LAST:      addr = sum_wrap[IDX_W-1:0];
         default:        addr = front_ff;
      endcase
   end

   always_comb begin
      unique case (ctl.front_op)
         FRONT_INC: front_in = front_inc;
         FRONT_DEC: front_in = front_dec;
         default:   front_in = front_ff;
      endcase
      unique case (ctl.count_op)
         COUNT_INC: count_in = count_ff + 1'b1;
         COUNT_DEC: count_in = count_ff - 1'b1;
         COUNT_CLR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         mem[addr] <= data_ff;
      end
      if (ctl.read) begin
         mem_q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_command;
         data_ff <= req_data_in;
      end
      if (ctl.rsp_en) begin
         rsp_status_ff <= ctl.rsp_status;
         unique case (ctl.rsp_sel)
            RSP_SIZE: rsp_value_ff <= WORD_W'(count_ff);
            RSP_MEM:  rsp_value_ff <= mem_q_ff;
            default:  rsp_value_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= ctl.rsp_en;
      end
   end

   assign dp_status = {cmd_ff, (count_ff == '0), (count_ff == CNT_FULL)};

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

`default_nettype wire

### hdl/double_ended_queue_unit.sv
// Double-ended queue of 32-bit words in a ring buffer of DEPTH slots.
// Each transaction is registered on start and answered with rsp_strobe; pops and
// peeks of a non-empty queue add a state for the registered memory read.
// One transaction is handled at a time; busy is high meanwhile.
// Results are not back-pressured. Synchronous reset empties the queue
// and sets the front to slot 0; slot contents are left undefined.
`default_nettype none

module double_ended_queue_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_command,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_data_in,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_value
);
   import deq_pkg::*;

   ctl_type        ctl;
   dp_status_type  dp_status;
   rsp_status_type rsp_status_e;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .ctl       (ctl),
      .busy      (busy)
   );

   deq_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_command (cmd_type'(req_command)),
      .req_data_in (req_data_in),
      .dp_status   (dp_status),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status_e),
      .rsp_value   (rsp_value)
   );

   assign rsp_status = rsp_status_e;

endmodule

`default_nettype wire

### tb/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [2:0]                        req_command,
   input  wire logic signed [deq_pkg::WORD_W-1:0] req_data_in,
   input  wire logic                              rsp_strobe,
   input  wire logic [1:0]                        rsp_status,
   input  wire logic signed [deq_pkg::WORD_W-1:0] rsp_value,
   output int                                     error_count,
   output int                                     waiting_count
);
   import deq_pkg::*;

   typedef struct packed {
      rsp_status_type    status;
      logic [WORD_W-1:0] value;
   } outcome_type;

   logic [WORD_W-1:0] slot_mem [DEPTH];
   logic [IDX_W-1:0]  head_slot;
   logic [CNT_W-1:0]  fill_level;
   outcome_type       outcome_q [$];
   outcome_type       wanted;
   outcome_type       predicted;

   function automatic logic [IDX_W-1:0] ring_offset(input logic [CNT_W-1:0] offset);
      return IDX_W'((int'(head_slot) + int'(offset)) % DEPTH);
   endfunction

   task automatic apply_command(input cmd_type cmd, input logic [WORD_W-1:0] word,
                                output outcome_type res);
      logic [IDX_W-1:0] slot;
      res.status = ST_OK;
      res.value  = '0;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (fill_level == CNT_FULL) begin
               res.status = ST_ERROR;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  head_slot = ring_offset(CNT_W'(DEPTH - 1));
                  slot = head_slot;
               end else begin
                  slot = ring_offset(fill_level);
               end
               slot_mem[slot] = word;
               fill_level = fill_level + 1'b1;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK: begin
            if (fill_level == '0) begin
               res.status = ST_ERROR;
            end else begin
               if (cmd == CMD_POP_FRONT || cmd == CMD_FRONT) begin
                  slot = head_slot;
               end else begin
                  slot = ring_offset(fill_level - 1'b1);
               end
               res.status = ST_VALUE;
               res.value  = slot_mem[slot];
               if (cmd == CMD_POP_FRONT) begin
                  head_slot = ring_offset(CNT_W'(1));
                  fill_level = fill_level - 1'b1;
               end else if (cmd == CMD_POP_BACK) begin
                  fill_level = fill_level - 1'b1;
               end
            end
         end
         CMD_SIZE: begin
            res.status = ST_VALUE;
            res.value  = WORD_W'(fill_level);
         end
         default: begin
            fill_level = '0;
         end
      endcase
   endtask

   task automatic note_failure(input string what, input outcome_type exp_item);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s: expected status %0d value %h, got status %0d value %h",
                  $realtime, what, exp_item.status, exp_item.value, rsp_status, rsp_value);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_slot = '0;
         fill_level = '0;
         outcome_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               note_failure("result with no transaction pending", '0);
            end else begin
               wanted = outcome_q[0];
               outcome_q.delete(0);
               if (wanted.status != rsp_status || wanted.value != rsp_value) begin
                  note_failure("result mismatch", wanted);
               end
            end
         end
         if (start && !busy) begin
            apply_command(cmd_type'(req_command), req_data_in, predicted);
            outcome_q = {outcome_q, predicted};
         end
      end
      waiting_count = outcome_q.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import deq_pkg::*;

   typedef enum int {
      PHASE_MIX,
      PHASE_FILL,
      PHASE_DRAIN
   } phase_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [2:0]               req_command = '0;
   logic signed [WORD_W-1:0] req_data_in = '0;
   wire logic                busy;
   wire logic                rsp_strobe;
   wire logic [1:0]          rsp_status;
   wire logic signed [WORD_W-1:0] rsp_value;
   int                       error_count;
   int                       waiting_count;
   int                       burst_left = 0;

   cmd_type directed_cmds [25] = '{
      CMD_SIZE, CMD_POP_FRONT, CMD_POP_BACK, CMD_FRONT, CMD_BACK,
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_FRONT, CMD_BACK, CMD_SIZE,
      CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_POP_BACK, CMD_POP_FRONT, CMD_POP_FRONT,
      CMD_POP_BACK, CMD_POP_BACK, CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_CLEAR,
      CMD_SIZE, CMD_FRONT, CMD_PUSH_BACK, CMD_BACK, CMD_POP_FRONT
   };
   logic [WORD_W-1:0] directed_words [25] = '{
      32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 32'h0,
      32'h00000000, 32'hffffffff, 32'h0, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h5a5a5a5a, 32'ha5a5a5a5, 32'h0,
      32'h0, 32'h0, 32'h12345678, 32'h0, 32'h0
   };

   double_ended_queue_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_data_in (req_data_in),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value)
   );

   deq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_data_in   (req_data_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value     (rsp_value),
      .error_count   (error_count),
      .waiting_count (waiting_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'h00000000;
         3: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic cmd_type pick_command(input phase_type phase);
      int roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_FILL: begin
            if (roll < 95) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            return cmd_type'($urandom_range(4, 6));
         end
         PHASE_DRAIN: begin
            if (roll < 70) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            if (roll < 80) return $urandom_range(0, 1) ? CMD_BACK : CMD_FRONT;
            if (roll < 88) return CMD_SIZE;
            if (roll < 99) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            return CMD_CLEAR;
         end
         default: begin
            if (roll < 2) return CMD_CLEAR;
            return cmd_type'($urandom_range(0, 6));
         end
      endcase
   endfunction

   task automatic send_item(input cmd_type cmd, input logic [WORD_W-1:0] word);
      bit taken;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_data_in <= word;
      do begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      burst_left--;
   endtask

   task automatic run_phase(input phase_type phase, input int count);
      cmd_type cmd;
      repeat (count) begin
         cmd = pick_command(phase);
         send_item(cmd, (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) ? pick_word()
                                                                        : $urandom);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(negedge clock);
      while (waiting_count != 0) @(negedge clock);
      burst_left = 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_cmds[i]) send_item(directed_cmds[i], directed_words[i]);
      run_phase(PHASE_MIX, 300);
      run_phase(PHASE_FILL, 1100);
      wait_drained();
      run_phase(PHASE_DRAIN, 400);
      run_phase(PHASE_MIX, 75);
      start <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0 && waiting_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule

### double_ended_queue_unit.f
hdl/deq_pkg.sv
hdl/deq_ctrl.sv
hdl/deq_datapath.sv
hdl/double_ended_queue_unit.sv
tb/deq_checker.sv
tb/testbench.sv
